>>> rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, codes and defaults of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Default sizes of the segment table and the heap layout.
  localparam int unsigned MaxBlocksDef   = 64;
  localparam int unsigned PageBytesDef   = 4096;
  localparam int unsigned HeaderBytesDef = 36;

  // The heap never grows past this many bytes.
  localparam int unsigned AddrSpan = 16777216;

  // Configuration register indexes.
  localparam logic [1:0] REG_INIT_BYTES = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES  = 2'd1;
  localparam logic [1:0] REG_MIN_SPLIT  = 2'd2;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_REALLOC = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_INIT    = 3'd1,
    ST_NULL        = 3'd2,
    ST_NO_MEM      = 3'd3,
    ST_BAD_BLOCK   = 3'd4,
    ST_DOUBLE_FREE = 3'd5
  } status_t;

  typedef enum logic {
    SCAN_FIT,
    SCAN_FIND
  } scan_mode_t;

  typedef enum logic [1:0] {
    MOD_NONE,
    MOD_WRITE,
    MOD_SPLIT,
    MOD_REMOVE
  } mod_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_FIT_SCAN,
    S_FIT_DONE,
    S_ALLOC,
    S_FIND_SCAN,
    S_FIND_DONE,
    S_REMOVE,
    S_DONE
  } state_t;

  // One segment of the table.
  typedef struct packed {
    logic [23:0] start;
    logic [24:0] size;
    logic        used;
  } seg_t;

  // What every cell compares against during a scan.
  typedef struct packed {
    scan_mode_t  mode;
    logic [25:0] need;
    logic [24:0] off;
  } scan_cmd_t;

  // Table update broadcast to all cells.
  typedef struct packed {
    mod_op_t op;
    seg_t    a;
    seg_t    b;
  } mod_t;

  // Scan packet that travels one cell per cycle.
  typedef struct packed {
    logic valid;
    logic found;
    logic jf;
    seg_t hit;
    seg_t prev;
    seg_t carry;
    seg_t last;
    logic next_valid;
    seg_t next;
  } scan_pkt_t;

  // Round a request up to the 8-byte grain.
  function automatic logic [25:0] round8(input logic [24:0] v);
    logic [25:0] t;
    t = {1'b0, v} + 26'd7;
    return {t[25:3], 3'b000};
  endfunction

endpackage
`default_nettype wire

>>> rtl/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with coalescing over a row of segment cells.
//
//   Channel   Signals                                  Beat taken when
//   command   start, busy, action, request_size,       start && !busy
//             data_offset
//   result    done, status, result_offset,             done (one cycle)
//             granted_size
//   config    psel, penable, pwrite, paddr, pwdata,    psel && penable && pwrite
//             prdata, pready
//
// Each table scan sends a packet down the row of MAX_BLOCKS cells, one cell a
// cycle; the sequencer then decides on the returned packet. An allocate runs a
// fit scan and then writes the table, a free may end with two removals after a
// double merge, and a reallocate may run a find, a fit, then a free. A command
// rejected at once goes straight to its result beat. Reset is synchronous and
// needs no clearing pass. Results cannot be held off: each result beat is shown
// once.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core import ffha_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
  parameter int unsigned PAGE_BYTES   = PageBytesDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [24:0] request_size,
  input  wire logic [24:0] data_offset,
  output logic             done,
  output logic [2:0]       status,
  output logic [24:0]      result_offset,
  output logic [24:0]      granted_size,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  logic [24:0] init_bytes;
  logic [24:0] max_bytes;
  logic [12:0] min_split;

  scan_cmd_t       scan_cmd;
  mod_t            mod;
  logic [IdxW-1:0] mod_pos;
  logic [CntW-1:0] count;
  seg_t            segs     [MAX_BLOCKS];
  scan_pkt_t       pkt_ch   [MAX_BLOCKS+1];
  logic [IdxW-1:0] idx_ch   [MAX_BLOCKS+1];

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      init_bytes <= 25'd1048576;
      max_bytes  <= 25'd16777216;
      min_split  <= 13'd32;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_INIT_BYTES: init_bytes <= pwdata[24:0];
        REG_MAX_BYTES:  max_bytes  <= pwdata[24:0];
        REG_MIN_SPLIT:  min_split  <= pwdata[12:0];
        default: begin
          min_split <= min_split;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INIT_BYTES: prdata = {7'd0, init_bytes};
      REG_MAX_BYTES:  prdata = {7'd0, max_bytes};
      REG_MIN_SPLIT:  prdata = {19'd0, min_split};
      default:        prdata = '0;
    endcase
  end

  // Sequencer.
  ffha_seq #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .request_size (request_size),
    .data_offset  (data_offset),
    .init_bytes   (init_bytes),
    .max_bytes    (max_bytes),
    .min_split    (min_split),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .result_offset(result_offset),
    .granted_size (granted_size),
    .scan_cmd     (scan_cmd),
    .pkt_head     (pkt_ch[0]),
    .pkt_tail     (pkt_ch[MAX_BLOCKS]),
    .idx_tail     (idx_ch[MAX_BLOCKS]),
    .mod          (mod),
    .mod_pos      (mod_pos),
    .count        (count)
  );

  assign idx_ch[0] = '0;

  // Row of segment cells.
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    seg_t left_seg;
    seg_t right_seg;
    if (k == 0) begin : g_first
      assign left_seg = segs[k];
    end else begin : g_mid_l
      assign left_seg = segs[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign right_seg = segs[k];
    end else begin : g_mid_r
      assign right_seg = segs[k+1];
    end

    ffha_cell #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .HEADER_BYTES(HEADER_BYTES),
      .CELL_IDX    (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .scan_cmd(scan_cmd),
      .mod     (mod),
      .mod_pos (mod_pos),
      .left    (left_seg),
      .right   (right_seg),
      .cur     (segs[k]),
      .pkt_in  (pkt_ch[k]),
      .idx_in  (idx_ch[k]),
      .pkt_out (pkt_ch[k+1]),
      .idx_out (idx_ch[k+1])
    );
  end

endmodule
`default_nettype wire

>>> rtl/ffha_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_cell
// One table entry: holds a segment, evaluates the passing scan packet and
// shifts with its neighbours when segments are inserted or removed.
// ----------------------------------------------------------------------------
module ffha_cell import ffha_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef,
  parameter int unsigned CELL_IDX     = 0,
  localparam int unsigned IdxW = $clog2(MAX_BLOCKS),
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [CntW-1:0] count,
  input  wire scan_cmd_t       scan_cmd,
  input  wire mod_t            mod,
  input  wire logic [IdxW-1:0] mod_pos,
  input  wire seg_t            left,
  input  wire seg_t            right,
  output seg_t                 cur,
  input  wire scan_pkt_t       pkt_in,
  input  wire logic [IdxW-1:0] idx_in,
  output scan_pkt_t            pkt_out,
  output logic [IdxW-1:0]      idx_out
);

  localparam logic [IdxW-1:0] MyIdx  = IdxW'(CELL_IDX);
  localparam logic [IdxW:0]   MyIdxW = (IdxW + 1)'(CELL_IDX);
  localparam logic [CntW-1:0] MyCnt  = CntW'(CELL_IDX);
  localparam logic [CntW-1:0] MyCnt1 = CntW'(CELL_IDX + 1);

  logic [23:0] seg_start;
  logic [24:0] seg_size;
  logic        seg_used;
  seg_t        seg_next;
  scan_pkt_t   pkt_next;
  logic [IdxW-1:0] idx_next;
  logic        in_use;
  logic        hit;
  logic [IdxW:0] pos_plus1;

  assign cur = '{start: seg_start, size: seg_size, used: seg_used};

  // Table update from the broadcast command.
  assign pos_plus1 = {1'b0, mod_pos} + {{IdxW{1'b0}}, 1'b1};
  always_comb begin
    seg_next = cur;
    case (mod.op)
      MOD_WRITE: begin
        if (mod_pos == MyIdx) seg_next = mod.a;
      end
      MOD_SPLIT: begin
        if (mod_pos == MyIdx) begin
          seg_next = mod.a;
        end else if (pos_plus1 == MyIdxW) begin
          seg_next = mod.b;
        end else if (MyIdxW > pos_plus1) begin
          seg_next = left;
        end
      end
      MOD_REMOVE: begin
        if (MyIdx >= mod_pos) seg_next = right;
      end
      default: begin
        seg_next = cur;
      end
    endcase
  end

  // Segment storage; only the used mark has a reset value.
  always_ff @(posedge clk) begin
    seg_start <= seg_next.start;
    seg_size  <= seg_next.size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_used <= 1'b0;
    end else begin
      seg_used <= seg_next.used;
    end
  end

  // Scan evaluation against this entry.
  assign in_use = MyCnt < count;
  always_comb begin
    if (scan_cmd.mode == SCAN_FIT) begin
      hit = in_use && !seg_used && ({1'b0, seg_size} >= scan_cmd.need);
    end else begin
      hit = in_use && (({1'b0, seg_start} + 25'(HEADER_BYTES)) == scan_cmd.off);
    end
  end

  always_comb begin
    pkt_next       = pkt_in;
    idx_next       = idx_in;
    pkt_next.carry = cur;
    pkt_next.jf    = 1'b0;
    if (pkt_in.valid) begin
      if (!pkt_in.found && hit) begin
        pkt_next.found = 1'b1;
        pkt_next.hit   = cur;
        pkt_next.prev  = pkt_in.carry;
        pkt_next.jf    = 1'b1;
        idx_next       = MyIdx;
      end
      if (pkt_in.jf && in_use) begin
        pkt_next.next_valid = 1'b1;
        pkt_next.next       = cur;
      end
      if (MyCnt1 == count) pkt_next.last = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out <= '0;
      idx_out <= '0;
    end else begin
      pkt_out <= pkt_next;
      idx_out <= idx_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ffha_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_seq
// Sequencer: launches scans down the cell row, decides on the returned
// packet and broadcasts table updates, growth and merges.
// ----------------------------------------------------------------------------
module ffha_seq import ffha_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
  parameter int unsigned PAGE_BYTES   = PageBytesDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef,
  localparam int unsigned IdxW = $clog2(MAX_BLOCKS),
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      action,
  input  wire logic [24:0]     request_size,
  input  wire logic [24:0]     data_offset,
  input  wire logic [24:0]     init_bytes,
  input  wire logic [24:0]     max_bytes,
  input  wire logic [12:0]     min_split,
  output logic                 busy,
  output logic                 done,
  output logic [2:0]           status,
  output logic [24:0]          result_offset,
  output logic [24:0]          granted_size,
  output scan_cmd_t            scan_cmd,
  output scan_pkt_t            pkt_head,
  input  wire scan_pkt_t       pkt_tail,
  input  wire logic [IdxW-1:0] idx_tail,
  output mod_t                 mod,
  output logic [IdxW-1:0]      mod_pos,
  output logic [CntW-1:0]      count
);

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [24:0]     Hdr25  = 25'(HEADER_BYTES);

  state_t          state;
  state_t          state_next;
  action_t         act_in;
  status_t         st;
  status_t         idle_status;
  logic [24:0]     req;
  logic [24:0]     off;
  logic [25:0]     need;
  logic            purpose_free;
  logic            zero_req;
  logic            pend_free;
  logic [24:0]     heap;
  logic            ready;
  logic [24:0]     roff;
  logic [24:0]     granted;
  logic            inject;
  scan_pkt_t       pkt;
  logic [IdxW-1:0] pidx;
  logic [IdxW-1:0] sel_idx;
  logic [23:0]     sel_start;
  logic [24:0]     sel_size;
  logic [1:0]      rem_left;
  logic [IdxW-1:0] rem_pos;

  logic [24:0] lim;
  logic [24:0] grow_base;
  logic [27:0] grow_src;
  logic [27:0] grow_q;
  logic [27:0] grow_sz;
  logic        grow_fit;
  logic        last_free;
  logic        room;
  logic        split_ok;
  logic        merge_prev;
  logic        merge_next;
  logic [IdxW-1:0] cnt_idx;

  assign act_in  = action_t'(action);
  assign cnt_idx = count[IdxW-1:0];

  // Page growth arithmetic, shared by init and by allocation.
  // Init starts from an empty heap, so its growth is checked from zero.
  assign lim       = (max_bytes > 25'(AddrSpan)) ? 25'(AddrSpan) : max_bytes;
  assign grow_base = (state == S_INIT) ? 25'd0 : heap;
  assign grow_src  = (state == S_INIT) ? {3'b000, init_bytes}
                                       : {2'b00, need} + 28'(HEADER_BYTES);
  assign grow_q    = (grow_src + 28'(PAGE_BYTES - 1)) / 28'(PAGE_BYTES);
  assign grow_sz   = 28'(grow_q * 28'(PAGE_BYTES));
  assign grow_fit  = (grow_sz != 28'd0) &&
                     (({4'b0000, grow_base} + {1'b0, grow_sz}) <= {4'b0000, lim});
  assign last_free = (count != '0) && !pkt.last.used;
  assign room      = count < CntMax;
  assign split_ok  = ({2'b00, sel_size} >=
                      ({1'b0, need} + 27'(HEADER_BYTES) + {14'd0, min_split})) && room;
  assign merge_prev = !pkt.prev.used;
  assign merge_next = pkt.next_valid && !pkt.next.used;

  // Decision on a newly accepted command.
  always_comb begin
    idle_status = ST_OK;
    case (act_in)
      ACT_ALLOC: begin
        if (!ready) idle_status = ST_NOT_INIT;
        else if (request_size == '0) idle_status = ST_NULL;
      end
      ACT_FREE: begin
        if (data_offset != '0 && !ready) idle_status = ST_NOT_INIT;
      end
      ACT_REALLOC: begin
        if (!ready) idle_status = ST_NOT_INIT;
        else if (data_offset == '0 && request_size == '0) idle_status = ST_NULL;
      end
      default: begin
        idle_status = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (act_in == ACT_INIT) begin
            state_next = S_INIT;
          end else if (idle_status != ST_OK) begin
            state_next = S_DONE;
          end else if (act_in == ACT_FREE) begin
            state_next = (data_offset == '0) ? S_DONE : S_FIND_SCAN;
          end else if (act_in == ACT_ALLOC || data_offset == '0) begin
            state_next = S_FIT_SCAN;
          end else begin
            state_next = S_FIND_SCAN;
          end
        end
      end
      S_INIT: begin
        state_next = S_DONE;
      end
      S_FIT_SCAN: begin
        if (pkt_tail.valid) state_next = S_FIT_DONE;
      end
      S_FIT_DONE: begin
        if (pkt.found || (grow_fit && (last_free || room))) state_next = S_ALLOC;
        else state_next = S_DONE;
      end
      S_ALLOC: begin
        state_next = pend_free ? S_FIND_SCAN : S_DONE;
      end
      S_FIND_SCAN: begin
        if (pkt_tail.valid) state_next = S_FIND_DONE;
      end
      S_FIND_DONE: begin
        if (!pkt.found || !pkt.hit.used) begin
          state_next = S_DONE;
        end else if (!purpose_free) begin
          state_next = ({1'b0, req} <= {1'b0, pkt.hit.size}) ? S_DONE : S_FIT_SCAN;
        end else if (merge_prev || merge_next) begin
          state_next = S_REMOVE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_REMOVE: begin
        if (rem_left == 2'd1) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs: handshake, scan launch and table updates.
  always_comb begin
    busy    = state != S_IDLE;
    done    = state == S_DONE;
    status  = st;
    result_offset = (st == ST_OK) ? roff : '0;
    granted_size  = (st == ST_OK) ? granted : '0;
    scan_cmd.mode = (state == S_FIT_SCAN) ? SCAN_FIT : SCAN_FIND;
    scan_cmd.need = need;
    scan_cmd.off  = off;
    pkt_head            = '0;
    pkt_head.valid      = inject;
    pkt_head.carry.used = 1'b1;
    pkt_head.last.used  = 1'b1;
    mod     = '0;
    mod_pos = '0;
    case (state)
      S_INIT: begin
        if (grow_fit) begin
          mod.op = MOD_WRITE;
          mod.a  = '{start: 24'd0, size: 25'(grow_sz - 28'(HEADER_BYTES)), used: 1'b0};
        end
      end
      S_FIT_DONE: begin
        if (!pkt.found && grow_fit) begin
          if (last_free) begin
            mod.op  = MOD_WRITE;
            mod_pos = cnt_idx - IdxW'(1);
            mod.a   = '{start: pkt.last.start,
                        size: 25'({3'b000, pkt.last.size} + grow_sz), used: 1'b0};
          end else if (room) begin
            mod.op  = MOD_WRITE;
            mod_pos = cnt_idx;
            mod.a   = '{start: heap[23:0],
                        size: 25'(grow_sz - 28'(HEADER_BYTES)), used: 1'b0};
          end
        end
      end
      S_ALLOC: begin
        mod_pos = sel_idx;
        if (split_ok) begin
          mod.op = MOD_SPLIT;
          mod.a  = '{start: sel_start, size: need[24:0], used: 1'b1};
          mod.b  = '{start: 24'({1'b0, sel_start} + Hdr25 + need[24:0]),
                     size: sel_size - need[24:0] - Hdr25, used: 1'b0};
        end else begin
          mod.op = MOD_WRITE;
          mod.a  = '{start: sel_start, size: sel_size, used: 1'b1};
        end
      end
      S_FIND_DONE: begin
        if (pkt.found && pkt.hit.used && purpose_free) begin
          mod.op = MOD_WRITE;
          if (merge_prev && merge_next) begin
            mod_pos = pidx - IdxW'(1);
            mod.a   = '{start: pkt.prev.start,
                        size: pkt.prev.size + Hdr25 + pkt.hit.size + Hdr25 + pkt.next.size,
                        used: 1'b0};
          end else if (merge_prev) begin
            mod_pos = pidx - IdxW'(1);
            mod.a   = '{start: pkt.prev.start,
                        size: pkt.prev.size + Hdr25 + pkt.hit.size, used: 1'b0};
          end else if (merge_next) begin
            mod_pos = pidx;
            mod.a   = '{start: pkt.hit.start,
                        size: pkt.hit.size + Hdr25 + pkt.next.size, used: 1'b0};
          end else begin
            mod_pos = pidx;
            mod.a   = '{start: pkt.hit.start, size: pkt.hit.size, used: 1'b0};
          end
        end
      end
      S_REMOVE: begin
        mod.op  = MOD_REMOVE;
        mod_pos = rem_pos;
      end
      default: begin
        mod = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      inject <= 1'b0;
      count  <= '0;
      heap   <= '0;
      ready  <= 1'b0;
    end else begin
      state  <= state_next;
      inject <= (state_next != state) &&
                (state_next == S_FIT_SCAN || state_next == S_FIND_SCAN);
      case (state)
        S_INIT: begin
          count <= grow_fit ? CntOne : '0;
          heap  <= grow_fit ? grow_sz[24:0] : '0;
          ready <= grow_fit;
        end
        S_FIT_DONE: begin
          if (!pkt.found && grow_fit && (last_free || room)) begin
            heap <= 25'({3'b000, heap} + grow_sz);
            if (!last_free) count <= count + CntOne;
          end
        end
        S_ALLOC: begin
          if (split_ok) count <= count + CntOne;
        end
        S_FIND_DONE: begin
          if (pkt.found && pkt.hit.used && purpose_free) begin
            if (merge_prev && merge_next) count <= count - CntW'(2);
            else if (merge_prev || merge_next) count <= count - CntOne;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          req          <= request_size;
          off          <= data_offset;
          need         <= round8(request_size);
          purpose_free <= (act_in == ACT_FREE) || (request_size == '0);
          zero_req     <= (act_in == ACT_REALLOC) && (request_size == '0);
          pend_free    <= 1'b0;
          st           <= idle_status;
          roff         <= '0;
          granted      <= '0;
        end
      end
      S_INIT: begin
        st <= grow_fit ? ST_OK : ST_NO_MEM;
      end
      S_FIT_SCAN, S_FIND_SCAN: begin
        if (pkt_tail.valid) begin
          pkt  <= pkt_tail;
          pidx <= idx_tail;
        end
      end
      S_FIT_DONE: begin
        if (pkt.found) begin
          sel_idx   <= pidx;
          sel_start <= pkt.hit.start;
          sel_size  <= pkt.hit.size;
        end else if (last_free) begin
          sel_idx   <= cnt_idx - IdxW'(1);
          sel_start <= pkt.last.start;
          sel_size  <= 25'({3'b000, pkt.last.size} + grow_sz);
        end else begin
          sel_idx   <= cnt_idx;
          sel_start <= heap[23:0];
          sel_size  <= 25'(grow_sz - 28'(HEADER_BYTES));
        end
        if (!pkt.found && !(grow_fit && (last_free || room))) st <= ST_NO_MEM;
      end
      S_ALLOC: begin
        st      <= ST_OK;
        roff    <= {1'b0, sel_start} + Hdr25;
        granted <= split_ok ? need[24:0] : sel_size;
      end
      S_FIND_DONE: begin
        if (!pkt.found) begin
          st <= ST_BAD_BLOCK;
        end else if (!pkt.hit.used) begin
          st <= ST_DOUBLE_FREE;
        end else if (!purpose_free) begin
          if ({1'b0, req} <= {1'b0, pkt.hit.size}) begin
            roff    <= off;
            granted <= pkt.hit.size;
          end else begin
            pend_free    <= 1'b1;
            purpose_free <= 1'b1;
          end
        end else begin
          if (zero_req) st <= ST_NULL;
          rem_left <= (merge_prev && merge_next) ? 2'd2 : 2'd1;
          rem_pos  <= merge_prev ? pidx : pidx + IdxW'(1);
        end
      end
      S_REMOVE: begin
        rem_left <= rem_left - 2'd1;
      end
      default: begin
        rem_left <= rem_left;
      end
    endcase
  end

  // A ready heap always holds at least one segment, never more than the table.
  assert property (@(posedge clk) disable iff (rst)
    ready |-> (count != '0) && (count <= CntMax))
    else $error("ready heap with an empty or overfull segment table");

  // A failed command never returns an offset or a size.
  assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (result_offset == '0) && (granted_size == '0))
    else $error("error beat carries a result");

  // A scan packet only leaves the row while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    pkt_tail.valid |-> (state == S_FIT_SCAN) || (state == S_FIND_SCAN))
    else $error("scan packet returned outside a scan");

  // A launched scan starts in a scan state.
  assert property (@(posedge clk) disable iff (rst)
    inject |-> (state == S_FIT_SCAN) || (state == S_FIND_SCAN))
    else $error("scan launched outside a scan");

endmodule
`default_nettype wire
